[rtl/core/sound_cpu_mailbox_irq_assert.svh]
// assertion macros for the mailbox block
`ifndef SOUND_CPU_MAILBOX_IRQ_ASSERT_SVH
`define SOUND_CPU_MAILBOX_IRQ_ASSERT_SVH

`ifndef SYNTH

// property that holds at every clock edge outside reset
`define SMI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SMI_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/core/scm_pkg.sv]
package scm_pkg;

	typedef enum logic [1:0] {
		KIND_MAIN_RD = 2'd0,
		KIND_MAIN_WR = 2'd1,
		KIND_SND_RD  = 2'd2,
		KIND_SND_WR  = 2'd3
	} kind_t;

	// main side word offsets
	localparam logic [2:0] MOFF_CMD0   = 3'd0;
	localparam logic [2:0] MOFF_CMD1   = 3'd1;
	localparam logic [2:0] MOFF_RPL0   = 3'd2;
	localparam logic [2:0] MOFF_RPL1   = 3'd3;
	localparam logic [2:0] MOFF_IRQ    = 3'd4;
	localparam logic [2:0] MOFF_STATUS = 3'd5;
	localparam logic [2:0] MOFF_SEND   = 3'd6;

	// sound side addresses, base removed
	localparam logic [4:0] SADDR_PEND   = 5'h00;
	localparam logic [4:0] SADDR_CLR    = 5'h01;
	localparam logic [4:0] SADDR_ACK    = 5'h03;
	localparam logic [4:0] SADDR_CMD0   = 5'h10;
	localparam logic [4:0] SADDR_CMD1   = 5'h11;
	localparam logic [4:0] SADDR_STATUS = 5'h12;
	localparam logic [4:0] SADDR_RPL0   = 5'h18;
	localparam logic [4:0] SADDR_RPL1   = 5'h19;

	localparam logic [7:0]  VEC_PENDING    = 8'hdf;
	localparam logic [7:0]  VEC_IDLE       = 8'hff;
	localparam logic [15:0] MAIN_UNMAPPED  = 16'hffff;
	localparam logic [15:0] SOUND_UNMAPPED = 16'h00ff;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  main_offset;
		logic        low_byte_enable;
		logic [4:0]  sound_addr;
		logic [15:0] write_data;
	} item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq_line;
		logic [7:0]  irq_vector;
	} result_t;

endpackage

[rtl/core/scm_if.sv]
interface scm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  main_offset;
	logic        low_byte_enable;
	logic [4:0]  sound_addr;
	logic [15:0] write_data;

	modport source (
		output valid, kind, main_offset, low_byte_enable, sound_addr, write_data,
		input  ready
	);
	modport sink (
		input  valid, kind, main_offset, low_byte_enable, sound_addr, write_data,
		output ready
	);
endinterface

interface scm_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        irq_line;
	logic [7:0]  irq_vector;

	modport source (
		output valid, read_data, irq_line, irq_vector,
		input  ready
	);
	modport sink (
		input  valid, read_data, irq_line, irq_vector,
		output ready
	);
endinterface

[rtl/core/scm_core.sv]
module scm_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            commit,
	input  scm_pkg::item_t   item,
	output scm_pkg::result_t result
);
	import scm_pkg::*;
	`include "sound_cpu_mailbox_irq_assert.svh"

	logic [1:0][7:0] cmd_q, cmd_d;
	logic [1:0][7:0] rpl_q, rpl_d;
	logic            cpend_q, cpend_d;
	logic            rpend_q, rpend_d;
	logic            irq_q, irq_d;
	logic [15:0]     rd;
	logic [7:0]      byte_in;

	assign byte_in = item.write_data[7:0];

	always_comb begin
		cmd_d   = cmd_q;
		rpl_d   = rpl_q;
		cpend_d = cpend_q;
		rpend_d = rpend_q;
		irq_d   = irq_q;
		rd      = '0;
		case (item.kind)
			KIND_MAIN_RD: begin
				case (item.main_offset)
					MOFF_RPL0:   rd = {8'h00, rpl_q[0]};
					MOFF_RPL1:   rd = {8'h00, rpl_q[1]};
					MOFF_STATUS: rd = {15'd0, cpend_q};
					default:     rd = MAIN_UNMAPPED;
				endcase
			end
			KIND_MAIN_WR: begin
				if (item.low_byte_enable) begin
					case (item.main_offset)
						MOFF_CMD0: cmd_d[0] = byte_in;
						MOFF_CMD1: cmd_d[1] = byte_in;
						MOFF_IRQ:  irq_d = 1'b1;
						MOFF_SEND: begin
							cpend_d = 1'b1;
							rpend_d = 1'b0;
						end
						default: ;
					endcase
				end
			end
			KIND_SND_RD: begin
				case (item.sound_addr)
					SADDR_CMD0:   rd = {8'h00, cmd_q[0]};
					SADDR_CMD1:   rd = {8'h00, cmd_q[1]};
					SADDR_STATUS: rd = {15'd0, rpend_q};
					default:      rd = SOUND_UNMAPPED;
				endcase
			end
			KIND_SND_WR: begin
				case (item.sound_addr)
					SADDR_PEND: begin
						cpend_d = 1'b0;
						rpend_d = 1'b1;
					end
					SADDR_CLR:  irq_d = 1'b0;
					SADDR_ACK:  irq_d = 1'b0;
					SADDR_RPL0: rpl_d[0] = byte_in;
					SADDR_RPL1: rpl_d[1] = byte_in;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= '0;
			rpl_q   <= '0;
			cpend_q <= 1'b0;
			rpend_q <= 1'b0;
			irq_q   <= 1'b0;
		end else if (commit) begin
			cmd_q   <= cmd_d;
			rpl_q   <= rpl_d;
			cpend_q <= cpend_d;
			rpend_q <= rpend_d;
			irq_q   <= irq_d;
		end
	end

	// interrupt changes show in the same access
	assign result.read_data  = rd;
	assign result.irq_line   = irq_d;
	assign result.irq_vector = irq_d ? VEC_PENDING : VEC_IDLE;

	`SMI_ASSERT(a_flags_exclusive, clk, arst_n, !(cpend_q && rpend_q), "both pending flags set")
	`SMI_ASSERT_NEXT(a_send_sets_flag, clk, arst_n, commit && item.kind == KIND_MAIN_WR && item.low_byte_enable && item.main_offset == MOFF_SEND, cpend_q && !rpend_q, "send did not mark command pending")
	`SMI_ASSERT_NEXT(a_ack_clears_irq, clk, arst_n, commit && item.kind == KIND_SND_WR && (item.sound_addr == SADDR_ACK || item.sound_addr == SADDR_CLR), !irq_q, "acknowledge left interrupt pending")

endmodule

[rtl/core/sound_cpu_mailbox_irq.sv]
// Mailbox between a main CPU and a sound CPU. Each request word is one bus
// access from either side; each access gives exactly one response word with
// the read data (0 for writes) and the sound CPU interrupt line and vector as
// they stand after that access. One access is taken every cycle while the
// response is not stalled; a request passes through the request register and
// then the response register, with all decoding and state update in the
// single logic stage between them. A stalled response holds the request
// register and drops request ready. Accesses take effect strictly in order.
module sound_cpu_mailbox_irq (
	input  logic      clk,
	input  logic      arst_n,
	scm_req_if.sink   req,
	scm_rsp_if.source rsp
);
	import scm_pkg::*;
	`include "sound_cpu_mailbox_irq_assert.svh"

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t res;
	logic    commit;

	assign commit    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.kind            <= kind_t'(req.kind);
			item_s1.main_offset     <= req.main_offset;
			item_s1.low_byte_enable <= req.low_byte_enable;
			item_s1.sound_addr      <= req.sound_addr;
			item_s1.write_data      <= req.write_data;
		end
		if (commit) begin
			out_q <= res;
		end
	end

	scm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.item   (item_s1),
		.result (res)
	);

	assign rsp.valid      = out_valid_q;
	assign rsp.read_data  = out_q.read_data;
	assign rsp.irq_line   = out_q.irq_line;
	assign rsp.irq_vector = out_q.irq_vector;

	`SMI_ASSERT_NEXT(a_commit_fills_out, clk, arst_n, commit, out_valid_q, "committed word not presented")
	`SMI_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !commit, valid_s1, "stalled request word lost")
	`SMI_ASSERT(a_no_overwrite, clk, arst_n, !(commit && out_valid_q && !rsp.ready), "response overwritten while stalled")

endmodule
